@@ hdl/cau_pkg.sv @@
// Shared widths, codes, bundle types and the clamp helper
// for the complex arithmetic unit. No dependencies.
package cau_pkg;

	localparam int W         = 16;          // operand and result width
	localparam int F         = 8;           // fraction bits
	localparam int PROD_W    = 2 * W;       // signed product width
	localparam int SUM_W     = 2 * W + 1;   // signed sum of two products
	localparam int MAG_W     = 2 * W;       // magnitude of such a sum
	localparam int ADD_W     = W + 1;       // signed sum of two operands
	localparam int QW        = W + 1;       // quotient bits, one below the result LSB
	localparam int DIV_STEPS = W + 1;       // one quotient bit per stage
	localparam int SH        = W - F;       // align for the overflow test
	localparam int OVF_W     = MAG_W + SH;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [PROD_W-1:0] rr;   // ar*br
		logic signed [PROD_W-1:0] ii;   // ai*bi
		logic signed [PROD_W-1:0] ri;   // ar*bi
		logic signed [PROD_W-1:0] ir;   // ai*br
		logic signed [PROD_W-1:0] bbr;  // br*br
		logic signed [PROD_W-1:0] bbi;  // bi*bi
		logic signed [ADD_W-1:0]  sum_re;
		logic signed [ADD_W-1:0]  sum_im;
	} prod_t;

	typedef struct packed {
		logic         div;      // divide result, take it from the quotients
		logic         dz;       // divide by zero
		logic         sat;      // saturation of the non-divide result
		logic [W-1:0] res_re;   // non-divide result
		logic [W-1:0] res_im;
		logic         neg_re;
		logic         neg_im;
		logic         ovf_re;   // quotient beyond the result range
		logic         ovf_im;
	} side_t;

	typedef struct packed {
		logic         sat;
		logic [W-1:0] val;
	} clamp_t;

	// signed magnitude to W bits, clamped
	function automatic clamp_t clamp(input logic neg, input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0] lim;
		clamp_t           c;
		lim = MAG_W'(1) << (W - 1);
		c.sat = 1'b0;
		if (neg) begin
			if (mag > lim) begin
				c.sat = 1'b1;
				c.val = W'(lim);
			end else begin
				c.val = W'(-mag);
			end
		end else begin
			if (mag > lim - MAG_W'(1)) begin
				c.sat = 1'b1;
				c.val = W'(lim - MAG_W'(1));
			end else begin
				c.val = W'(mag);
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/complex_arithmetic_unit_top.sv @@
// Complex arithmetic unit: add, subtract, multiply, divide on Q8.8 pairs.
// 22 register stages: input register, product stage, 2 combine stages, 17
// divider stages (one quotient bit each) and the output register. One
// transfer per cycle sustained while out_stall does not hold the pipeline.
// arst_n clears every valid bit at once; payload registers are not reset.
// Depends on cau_pkg, cau_mult, cau_prep and cau_div.
module complex_arithmetic_unit_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic signed [cau_pkg::W-1:0] first_real,
	input  logic signed [cau_pkg::W-1:0] first_imag,
	input  logic signed [cau_pkg::W-1:0] second_real,
	input  logic signed [cau_pkg::W-1:0] second_imag,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [cau_pkg::W-1:0] result_real,
	output logic signed [cau_pkg::W-1:0] result_imag,
	output logic [1:0]                   status
);

	localparam int N = cau_pkg::DIV_STEPS;

	// The whole pipeline moves as one; it only holds when the result in
	// the output register is offered and not taken. Empty slots are simply
	// carried along as invalid stages.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic                      valid_s2, valid_s4;
	cau_pkg::prod_t            prod_s2;
	cau_pkg::side_t            side_s4;
	logic [cau_pkg::MAG_W-1:0] num_re_s4, num_im_s4, den_s4;
	logic [cau_pkg::QW-1:0]    quo_re, quo_im;

	cau_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.mode     (mode),
		.ar       (first_real),
		.ai       (first_imag),
		.br       (second_real),
		.bi       (second_imag),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2)
	);

	cau_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_s2  (valid_s2),
		.prod_s2   (prod_s2),
		.valid_s4  (valid_s4),
		.side_s4   (side_s4),
		.num_re_s4 (num_re_s4),
		.num_im_s4 (num_im_s4),
		.den_s4    (den_s4)
	);

	// Two dividers, one per result part, sharing the denominator |b|^2.
	cau_div u_div_re (
		.clk (clk),
		.en  (en),
		.num (num_re_s4),
		.den (den_s4),
		.quo (quo_re)
	);

	cau_div u_div_im (
		.clk (clk),
		.en  (en),
		.num (num_im_s4),
		.den (den_s4),
		.quo (quo_im)
	);

	// Side information rides alongside the divider stages.
	logic           vld_d  [N];
	cau_pkg::side_t side_d [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				vld_d[k] <= 1'b0;
			end
		end else if (en) begin
			vld_d[0] <= valid_s4;
			for (int k = 1; k < N; k++) begin
				vld_d[k] <= vld_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s4;
			for (int k = 1; k < N; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// Finish: the quotient carries one extra bit below the result LSB, so
	// adding one and dropping it rounds half away from zero on the magnitude.
	cau_pkg::side_t            sd;
	logic [cau_pkg::QW:0]      inc_re, inc_im;
	logic [cau_pkg::MAG_W-1:0] dmag_re, dmag_im;
	cau_pkg::clamp_t           dc_re, dc_im;
	logic [cau_pkg::W-1:0]     fin_re, fin_im;
	logic [1:0]                fin_st;

	always_comb begin
		sd      = side_d[N-1];
		inc_re  = (cau_pkg::QW+1)'(quo_re) + (cau_pkg::QW+1)'(1);
		inc_im  = (cau_pkg::QW+1)'(quo_im) + (cau_pkg::QW+1)'(1);
		// an overflowed quotient is forced past the clamp limit
		dmag_re = sd.ovf_re ? '1 : cau_pkg::MAG_W'(inc_re[cau_pkg::QW:1]);
		dmag_im = sd.ovf_im ? '1 : cau_pkg::MAG_W'(inc_im[cau_pkg::QW:1]);
		dc_re   = cau_pkg::clamp(sd.neg_re, dmag_re);
		dc_im   = cau_pkg::clamp(sd.neg_im, dmag_im);
		if (sd.dz) begin
			fin_re = '0;
			fin_im = '0;
			fin_st = cau_pkg::ST_DZ;
		end else if (sd.div) begin
			fin_re = dc_re.val;
			fin_im = dc_im.val;
			fin_st = (dc_re.sat | dc_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end else begin
			fin_re = sd.res_re;
			fin_im = sd.res_im;
			fin_st = sd.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_d[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_real <= fin_re;
			result_imag <= fin_im;
			status      <= fin_st;
		end
	end

	// A divide-by-zero result always reads as zero.
	a_dz_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cau_pkg::ST_DZ |-> result_real == '0 && result_imag == '0)
		else $error("divide by zero result not zero");

	// Only the three defined status codes ever leave the block.
	a_status : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == cau_pkg::ST_OK || status == cau_pkg::ST_SAT
			|| status == cau_pkg::ST_DZ)
		else $error("undefined status code");

	// While held, the last divider stage keeps its item.
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_d[N-1]))
		else $error("pipeline moved during a hold");

endmodule

@@ hdl/cau_mult.sv @@
// Input register and product stage (s1, s2).
// Depends on cau_pkg.
module cau_mult (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [1:0]                  mode,
	input  logic signed [cau_pkg::W-1:0] ar,
	input  logic signed [cau_pkg::W-1:0] ai,
	input  logic signed [cau_pkg::W-1:0] br,
	input  logic signed [cau_pkg::W-1:0] bi,
	output logic                        valid_s2,
	output cau_pkg::prod_t              prod_s2
);

	logic                         valid_s1;
	logic [1:0]                   mode_s1;
	logic signed [cau_pkg::W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			ar_s1   <= ar;
			ai_s1   <= ai;
			br_s1   <= br;
			bi_s1   <= bi;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2.mode <= mode_s1;
			prod_s2.rr   <= cau_pkg::PROD_W'(ar_s1) * cau_pkg::PROD_W'(br_s1);
			prod_s2.ii   <= cau_pkg::PROD_W'(ai_s1) * cau_pkg::PROD_W'(bi_s1);
			prod_s2.ri   <= cau_pkg::PROD_W'(ar_s1) * cau_pkg::PROD_W'(bi_s1);
			prod_s2.ir   <= cau_pkg::PROD_W'(ai_s1) * cau_pkg::PROD_W'(br_s1);
			prod_s2.bbr  <= cau_pkg::PROD_W'(br_s1) * cau_pkg::PROD_W'(br_s1);
			prod_s2.bbi  <= cau_pkg::PROD_W'(bi_s1) * cau_pkg::PROD_W'(bi_s1);
			if (mode_s1 == cau_pkg::MODE_SUB) begin
				prod_s2.sum_re <= cau_pkg::ADD_W'(ar_s1) - cau_pkg::ADD_W'(br_s1);
				prod_s2.sum_im <= cau_pkg::ADD_W'(ai_s1) - cau_pkg::ADD_W'(bi_s1);
			end else begin
				prod_s2.sum_re <= cau_pkg::ADD_W'(ar_s1) + cau_pkg::ADD_W'(br_s1);
				prod_s2.sum_im <= cau_pkg::ADD_W'(ai_s1) + cau_pkg::ADD_W'(bi_s1);
			end
		end
	end

endmodule

@@ hdl/cau_prep.sv @@
// Combine products (s3), then round/clamp non-divide results and set up
// divider operands (s4). Depends on cau_pkg.
module cau_prep (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_s2,
	input  cau_pkg::prod_t               prod_s2,
	output logic                         valid_s4,
	output cau_pkg::side_t               side_s4,
	output logic [cau_pkg::MAG_W-1:0]    num_re_s4,
	output logic [cau_pkg::MAG_W-1:0]    num_im_s4,
	output logic [cau_pkg::MAG_W-1:0]    den_s4
);

	logic                            valid_s3;
	logic [1:0]                      mode_s3;
	logic signed [cau_pkg::SUM_W-1:0] re_s3, im_s3;
	logic [cau_pkg::MAG_W-1:0]       den_s3;
	logic signed [cau_pkg::ADD_W-1:0] sum_re_s3, sum_im_s3;

	// s4 logic
	logic                      neg_re, neg_im;
	logic [cau_pkg::MAG_W-1:0] mag_re, mag_im, rnd_re, rnd_im, sel_re, sel_im;
	logic                      sel_nre, sel_nim;
	cau_pkg::clamp_t           c_re, c_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3   <= prod_s2.mode;
			sum_re_s3 <= prod_s2.sum_re;
			sum_im_s3 <= prod_s2.sum_im;
			den_s3    <= cau_pkg::MAG_W'($unsigned(prod_s2.bbr))
				+ cau_pkg::MAG_W'($unsigned(prod_s2.bbi));
			if (prod_s2.mode == cau_pkg::MODE_MUL) begin
				re_s3 <= cau_pkg::SUM_W'(prod_s2.rr) - cau_pkg::SUM_W'(prod_s2.ii);
				im_s3 <= cau_pkg::SUM_W'(prod_s2.ri) + cau_pkg::SUM_W'(prod_s2.ir);
			end else begin
				re_s3 <= cau_pkg::SUM_W'(prod_s2.rr) + cau_pkg::SUM_W'(prod_s2.ii);
				im_s3 <= cau_pkg::SUM_W'(prod_s2.ir) - cau_pkg::SUM_W'(prod_s2.ri);
			end
		end
	end

	always_comb begin
		neg_re = re_s3[cau_pkg::SUM_W-1];
		neg_im = im_s3[cau_pkg::SUM_W-1];
		mag_re = neg_re ? cau_pkg::MAG_W'(-re_s3) : cau_pkg::MAG_W'(re_s3);
		mag_im = neg_im ? cau_pkg::MAG_W'(-im_s3) : cau_pkg::MAG_W'(im_s3);
		// round half away from zero on the magnitude
		rnd_re = (mag_re + (cau_pkg::MAG_W'(1) << (cau_pkg::F - 1))) >> cau_pkg::F;
		rnd_im = (mag_im + (cau_pkg::MAG_W'(1) << (cau_pkg::F - 1))) >> cau_pkg::F;
		if (mode_s3 == cau_pkg::MODE_MUL) begin
			sel_nre = neg_re;
			sel_nim = neg_im;
			sel_re  = rnd_re;
			sel_im  = rnd_im;
		end else begin
			sel_nre = sum_re_s3[cau_pkg::ADD_W-1];
			sel_nim = sum_im_s3[cau_pkg::ADD_W-1];
			sel_re  = sel_nre ? cau_pkg::MAG_W'(-sum_re_s3) : cau_pkg::MAG_W'(sum_re_s3);
			sel_im  = sel_nim ? cau_pkg::MAG_W'(-sum_im_s3) : cau_pkg::MAG_W'(sum_im_s3);
		end
		c_re = cau_pkg::clamp(sel_nre, sel_re);
		c_im = cau_pkg::clamp(sel_nim, sel_im);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.div    <= (mode_s3 == cau_pkg::MODE_DIV);
			side_s4.dz     <= (mode_s3 == cau_pkg::MODE_DIV) && (den_s3 == '0);
			side_s4.sat    <= c_re.sat | c_im.sat;
			side_s4.res_re <= c_re.val;
			side_s4.res_im <= c_im.val;
			side_s4.neg_re <= neg_re;
			side_s4.neg_im <= neg_im;
			// quotient needs more than the result range when num >= den * 2^(W-F)
			side_s4.ovf_re <= cau_pkg::OVF_W'(mag_re)
				>= (cau_pkg::OVF_W'(den_s3) << cau_pkg::SH);
			side_s4.ovf_im <= cau_pkg::OVF_W'(mag_im)
				>= (cau_pkg::OVF_W'(den_s3) << cau_pkg::SH);
			num_re_s4 <= mag_re;
			num_im_s4 <= mag_im;
			den_s4    <= den_s3;
		end
	end

endmodule

@@ hdl/cau_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 2^(F+1) / den) when it fits QW bits. Depends on cau_pkg.
module cau_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [cau_pkg::MAG_W-1:0] num,
	input  logic [cau_pkg::MAG_W-1:0] den,
	output logic [cau_pkg::QW-1:0]    quo
);

	localparam int N = cau_pkg::DIV_STEPS;

	logic [cau_pkg::MAG_W-1:0] rem_in [N];
	logic [cau_pkg::QW-1:0]    quo_in [N];
	logic [cau_pkg::MAG_W-1:0] num_in [N];
	logic [cau_pkg::MAG_W-1:0] den_in [N];

	logic [cau_pkg::MAG_W-1:0] rem_s [N];
	logic [cau_pkg::QW-1:0]    quo_s [N];
	logic [cau_pkg::MAG_W-1:0] num_s [N];
	logic [cau_pkg::MAG_W-1:0] den_s [N];

	assign rem_in[0] = num >> cau_pkg::SH;
	assign quo_in[0] = '0;
	assign num_in[0] = num;
	assign den_in[0] = den;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int J = N - 1 - k;   // dividend bit brought down here
		logic                      nbit;
		logic [cau_pkg::MAG_W:0]   t;
		logic [cau_pkg::MAG_W:0]   d;
		logic                      ge;

		if (k > 0) begin : g_link
			assign rem_in[k] = rem_s[k-1];
			assign quo_in[k] = quo_s[k-1];
			assign num_in[k] = num_s[k-1];
			assign den_in[k] = den_s[k-1];
		end

		if (J >= cau_pkg::F + 1) begin : g_bit
			assign nbit = num_in[k][J - cau_pkg::F - 1];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		assign t  = {rem_in[k], nbit};
		assign d  = {1'b0, den_in[k]};
		assign ge = (t >= d);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? cau_pkg::MAG_W'(t - d) : t[cau_pkg::MAG_W-1:0];
				quo_s[k] <= {quo_in[k][cau_pkg::QW-2:0], ge};
				num_s[k] <= num_in[k];
				den_s[k] <= den_in[k];
			end
		end
	end

	assign quo = quo_s[N-1];

endmodule
